// ===== src/ctp_pkg.sv =====
// types, record codes and helpers shared by the trajectory parser
// no dependencies
package ctp_pkg;

   localparam int unsigned NumAxes = 4;

   typedef enum logic [1:0] {
      REC_START  = 2'd0,
      REC_HEADER = 2'd1,
      REC_POINT  = 2'd2,
      REC_END    = 2'd3
   } record_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      record_kind_type    record_kind;
      logic [1:0]         axis;
      logic [2:0]         point_index;
      logic signed [15:0] coord_value;
      logic [1:0]         x_kind;
      logic [1:0]         y_kind;
      logic [1:0]         z_kind;
      logic [1:0]         yaw_kind;
      logic [15:0]        duration_ms;
      logic [31:0]        time_ms;
   } rsp_item_type;

   // control points stored per axis for each storage kind
   function automatic logic [2:0] points_of(input logic [1:0] kind);
      logic [2:0] n;
      unique case (kind)
         2'd0: n = 3'd0;
         2'd1: n = 3'd1;
         2'd2: n = 3'd3;
         default: n = 3'd7;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] kind_of(input logic [7:0] kinds, input logic [1:0] ax);
      return kinds[{ax, 1'b0} +: 2];
   endfunction

endpackage

// ===== src/ctp_parser.sv =====
// byte parser: stream state and the record that each byte completes
// depends on ctp_pkg
module ctp_parser
   import ctp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   output logic         rec_valid,
   output rsp_item_type rec
);

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_HEADER   = 3'd1,
      PH_DURATION = 3'd2,
      PH_POINTS   = 3'd3,
      PH_DONE     = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in, phase_e;
   logic [7:0]  low_ff, low_in, low_e;
   logic [7:0]  kinds_ff, kinds_in, kinds_e;
   logic [31:0] elapsed_ff, elapsed_in, elapsed_e;
   logic [1:0]  axis_ff, axis_in, axis_e;
   logic [2:0]  point_ff, point_in, point_e;
   logic        parity_ff, parity_in, parity_e;

   logic [15:0] word;
   logic [2:0]  next_axis;
   logic [3:0]  point_next;

   // first axis at or after start with control points, 4 when none
   function automatic logic [2:0] axis_from(input logic [7:0] kinds, input logic [2:0] start);
      logic [2:0] found;
      found = 3'd4;
      for (int a = NumAxes - 1; a >= 0; a--) begin
         if (3'(a) >= start && points_of(kind_of(kinds, 2'(a))) != 3'd0) begin
            found = 3'(a);
         end
      end
      return found;
   endfunction

   always_comb begin
      if (item.restart) begin
         phase_e   = PH_START;
         low_e     = '0;
         kinds_e   = '0;
         elapsed_e = '0;
         axis_e    = '0;
         point_e   = '0;
         parity_e  = 1'b0;
      end else begin
         phase_e   = phase_ff;
         low_e     = low_ff;
         kinds_e   = kinds_ff;
         elapsed_e = elapsed_ff;
         axis_e    = axis_ff;
         point_e   = point_ff;
         parity_e  = parity_ff;
      end

      phase_in   = phase_e;
      low_in     = low_e;
      kinds_in   = kinds_e;
      elapsed_in = elapsed_e;
      axis_in    = axis_e;
      point_in   = point_e;
      parity_in  = parity_e;
      rec_valid  = 1'b0;
      rec        = '0;
      word       = {item.data_byte, low_e};
      next_axis  = '0;
      point_next = {1'b0, point_e} + 4'd1;

      if (phase_e == PH_DONE) begin
         // trajectory ended, bytes ignored until restart
      end else if (phase_e == PH_HEADER) begin
         kinds_in  = item.data_byte;
         parity_in = 1'b0;
         phase_in  = PH_DURATION;
      end else if (!parity_e) begin
         low_in    = item.data_byte;
         parity_in = 1'b1;
      end else begin
         parity_in = 1'b0;
         rec_valid = 1'b1;
         unique case (phase_e)
            PH_START: begin
               rec.record_kind = REC_START;
               rec.axis        = axis_e;
               rec.coord_value = word;
               if (axis_e == 2'd3) begin
                  axis_in  = '0;
                  phase_in = PH_HEADER;
               end else begin
                  axis_in = axis_e + 2'd1;
               end
            end
            PH_DURATION: begin
               if (word == '0) begin
                  rec.record_kind = REC_END;
                  rec.time_ms     = elapsed_e;
                  phase_in        = PH_DONE;
               end else begin
                  rec.record_kind = REC_HEADER;
                  rec.x_kind      = kind_of(kinds_e, 2'd0);
                  rec.y_kind      = kind_of(kinds_e, 2'd1);
                  rec.z_kind      = kind_of(kinds_e, 2'd2);
                  rec.yaw_kind    = kind_of(kinds_e, 2'd3);
                  rec.duration_ms = word;
                  rec.time_ms     = elapsed_e;
                  elapsed_in      = elapsed_e + {16'd0, word};
                  point_in        = '0;
                  next_axis       = axis_from(kinds_e, 3'd0);
                  if (next_axis[2]) begin
                     axis_in  = '0;
                     phase_in = PH_HEADER;
                  end else begin
                     axis_in  = next_axis[1:0];
                     phase_in = PH_POINTS;
                  end
               end
            end
            PH_POINTS: begin
               rec.record_kind = REC_POINT;
               rec.axis        = axis_e;
               rec.point_index = point_next[2:0];
               rec.coord_value = word;
               if (point_next < {1'b0, points_of(kind_of(kinds_e, axis_e))}) begin
                  point_in = point_next[2:0];
               end else begin
                  point_in  = '0;
                  next_axis = axis_from(kinds_e, {1'b0, axis_e} + 3'd1);
                  if (next_axis[2]) begin
                     axis_in  = '0;
                     phase_in = PH_HEADER;
                  end else begin
                     axis_in = next_axis[1:0];
                  end
               end
            end
            default: begin
               rec_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         low_ff     <= '0;
         kinds_ff   <= '0;
         elapsed_ff <= '0;
         axis_ff    <= '0;
         point_ff   <= '0;
         parity_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         low_ff     <= low_in;
         kinds_ff   <= kinds_in;
         elapsed_ff <= elapsed_in;
         axis_ff    <= axis_in;
         point_ff   <= point_in;
         parity_ff  <= parity_in;
      end
   end

endmodule

// ===== src/compressed_trajectory_parser.sv =====
// compressed trajectory parser top level: input register, parser, result register
// depends on ctp_pkg and ctp_parser
//
//   channel | direction | transaction
//   req     | in        | one stream byte with restart flag (req_item_type)
//   rsp     | out       | one parsed record (rsp_item_type)
//
// one byte per cycle sustained while rsp_stall does not hold back the result register
// a byte is first registered in the input register, then the parser state and the
// result register update together once the result register can take a record
// synchronous reset clears the parser state and both valid flags
// rsp_stall holds the result register while it holds a record and, when the input
// register is full as well, raises req_stall in the same cycle
module compressed_trajectory_parser
   import ctp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   logic         advance;
   logic         step_en;
   logic         rec_valid;
   rsp_item_type rec;

   assign advance     = !out_valid_ff || !rsp_stall;
   assign step_en     = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = step_en ? rec_valid : (out_valid_ff && rsp_stall);

   ctp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .item      (in_item_ff),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
      if (step_en && rec_valid) begin
         out_item_ff <= rec;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// ===== tb/compressed_trajectory_parser_test.sv =====
// self-checking testbench for compressed_trajectory_parser: a byte-level parser model
// predicts every record of directed, random, broken and long trajectories
// depends on ctp_pkg and compressed_trajectory_parser
module compressed_trajectory_parser_test;
   import ctp_pkg::*;

   typedef enum logic [2:0] {
      EXPECT_START,
      EXPECT_HEADER,
      EXPECT_DURATION,
      EXPECT_POINTS,
      EXPECT_NOTHING
   } stream_phase_type;

   typedef struct {
      req_item_type item;
      bit           drain_first;
   } stream_byte_type;

   localparam int CycleLimit    = 1_200_000;
   localparam int RandomBytes   = 1400;
   localparam int ClosingPieces = 48;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   stream_byte_type pending_bytes[$];
   rsp_item_type    expected_records[$];

   // parser model state
   stream_phase_type ps_phase = EXPECT_START;
   logic [7:0]       ps_low = '0;
   logic [7:0]       ps_kinds = '0;
   logic [31:0]      ps_elapsed = '0;
   logic [1:0]       ps_axis = '0;
   logic [2:0]       ps_point = '0;
   logic             ps_half = 1'b0;

   int   accepted_bytes = 0;
   int   calm_from = 0;
   int   gap_left = 0;
   int   hold_left = 0;
   int   long_holds = 0;
   int   mismatches = 0;
   int   records_checked = 0;
   int   ends_seen = 0;
   int   cycle_count = 0;
   logic calm;

   assign calm = accepted_bytes >= calm_from;

   compressed_trajectory_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // storage kinds 0..3 hold 0, 1, 3, 7 points
   function automatic int stored_points(input logic [1:0] kind);
      return (1 << kind) - 1;
   endfunction

   function automatic int next_stored_axis(input int from);
      int a;
      a = from;
      while (a < NumAxes && stored_points(ps_kinds[2*a +: 2]) == 0) a++;
      return a;
   endfunction

   task automatic parse_byte(input req_item_type it);
      logic [15:0] word;
      rsp_item_type rec;
      int a;
      if (it.restart) begin
         ps_phase = EXPECT_START;
         ps_low = '0;
         ps_kinds = '0;
         ps_elapsed = '0;
         ps_axis = '0;
         ps_point = '0;
         ps_half = 1'b0;
      end
      if (ps_phase == EXPECT_NOTHING) return;
      if (ps_phase == EXPECT_HEADER) begin
         ps_kinds = it.data_byte;
         ps_half = 1'b0;
         ps_phase = EXPECT_DURATION;
         return;
      end
      if (!ps_half) begin
         ps_low = it.data_byte;
         ps_half = 1'b1;
         return;
      end
      ps_half = 1'b0;
      word = {it.data_byte, ps_low};
      rec = '0;
      case (ps_phase)
         EXPECT_START: begin
            rec.record_kind = REC_START;
            rec.axis = ps_axis;
            rec.coord_value = word;
            if (ps_axis == 2'd3) ps_phase = EXPECT_HEADER;
            ps_axis = ps_axis + 2'd1;
         end
         EXPECT_DURATION: begin
            rec.time_ms = ps_elapsed;
            if (word == 16'd0) begin
               rec.record_kind = REC_END;
               ps_phase = EXPECT_NOTHING;
            end else begin
               rec.record_kind = REC_HEADER;
               rec.x_kind = ps_kinds[1:0];
               rec.y_kind = ps_kinds[3:2];
               rec.z_kind = ps_kinds[5:4];
               rec.yaw_kind = ps_kinds[7:6];
               rec.duration_ms = word;
               ps_elapsed = ps_elapsed + word;
               a = next_stored_axis(0);
               ps_point = 3'd0;
               ps_axis = a[1:0];
               ps_phase = (a < NumAxes) ? EXPECT_POINTS : EXPECT_HEADER;
            end
         end
         default: begin
            rec.record_kind = REC_POINT;
            rec.axis = ps_axis;
            rec.point_index = ps_point + 3'd1;
            rec.coord_value = word;
            if (int'(ps_point) + 1 < stored_points(ps_kinds[2*ps_axis +: 2])) begin
               ps_point = ps_point + 3'd1;
            end else begin
               ps_point = 3'd0;
               a = next_stored_axis(int'(ps_axis) + 1);
               ps_axis = a[1:0];
               if (a >= NumAxes) ps_phase = EXPECT_HEADER;
            end
         end
      endcase
      expected_records.push_back(rec);
   endtask

   task automatic add_byte(input logic [7:0] b, input bit rs = 1'b0, input bit drain = 1'b0);
      stream_byte_type s;
      s.item.data_byte = b;
      s.item.restart = rs;
      s.drain_first = drain;
      pending_bytes.push_back(s);
   endtask

   task automatic add_word(input logic [15:0] w);
      add_byte(w[7:0]);
      add_byte(w[15:8]);
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_trajectory(input int pieces, input bit drain);
      logic [15:0] w;
      logic [7:0] kinds;
      w = random_word();
      add_byte(w[7:0], 1'b1, drain);
      add_byte(w[15:8]);
      repeat (3) add_word(random_word());
      repeat (pieces) begin
         kinds = 8'($urandom);
         w = random_word();
         if (w == 16'd0) w = 16'd1;
         add_byte(kinds);
         add_word(w);
         for (int a = 0; a < NumAxes; a++)
            repeat (stored_points(kinds[2*a +: 2])) add_word(random_word());
      end
      add_byte(8'($urandom));
      add_word(16'd0);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < 20)
         $display("mismatch on %s at record %0d: got %0h, expected %0h",
                  what, records_checked, got, want);
      mismatches++;
   endtask

   task automatic compare_record(input rsp_item_type got, input rsp_item_type want);
      if (got.record_kind !== want.record_kind)
         report("record_kind", got.record_kind, want.record_kind);
      if (got.axis !== want.axis) report("axis", got.axis, want.axis);
      if (got.point_index !== want.point_index)
         report("point_index", got.point_index, want.point_index);
      if (got.coord_value !== want.coord_value)
         report("coord_value", got.coord_value, want.coord_value);
      if (got.x_kind !== want.x_kind) report("x_kind", got.x_kind, want.x_kind);
      if (got.y_kind !== want.y_kind) report("y_kind", got.y_kind, want.y_kind);
      if (got.z_kind !== want.z_kind) report("z_kind", got.z_kind, want.z_kind);
      if (got.yaw_kind !== want.yaw_kind) report("yaw_kind", got.yaw_kind, want.yaw_kind);
      if (got.duration_ms !== want.duration_ms)
         report("duration_ms", got.duration_ms, want.duration_ms);
      if (got.time_ms !== want.time_ms) report("time_ms", got.time_ms, want.time_ms);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data);
            accepted_bytes <= accepted_bytes + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() == 0
                         || (pending_bytes[0].drain_first && expected_records.size() != 0)) begin
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
               gap_left <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else begin
               req_data <= pending_bytes[0].item;
               void'(pending_bytes.pop_front());
               req_valid <= 1'b1;
            end
         end
      end
   end

   // record monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               report("record with nothing pending", rsp_data.record_kind, 0);
            end else begin
               compare_record(rsp_data, expected_records.pop_front());
               records_checked++;
            end
            if (rsp_data.record_kind == REC_END) ends_seen++;
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && long_holds < 2 && accepted_bytes >= 300 + 700 * long_holds) begin
            // long hold-off so the block backs up into its input
            hold_left <= 59;
            long_holds <= long_holds + 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            hold_left <= $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("compressed_trajectory_parser_test NOT OK");
         $finish;
      end
   end

   initial begin
      int start;
      int counted;
      int cut;
      int round;
      bit drain;

      // directed: extreme start coordinates, empty piece, mixed kinds, end, restarts
      add_byte(8'h00, 1'b1);
      add_byte(8'h80);
      add_word(16'h7fff);
      add_word(16'h0000);
      add_word(16'hffff);
      add_byte(8'h00);
      add_word(16'hffff);
      add_byte(8'h09);
      add_word(16'h0001);
      add_word(16'h8000);
      add_word(16'h7fff);
      add_word(16'h0001);
      add_word(16'hfffe);
      add_byte(8'hff);
      add_word(16'h0000);
      add_byte(8'h5a);
      add_byte(8'h34, 1'b1);
      add_byte(8'h12, 1'b1);
      add_byte(8'h80);

      counted = 0;
      round = 0;
      while (counted < RandomBytes) begin
         start = pending_bytes.size();
         drain = (round % 8 == 3);
         case ($urandom_range(0, 9))
            0: begin
               add_byte(8'($urandom), 1'b1, drain);
               repeat ($urandom_range(4, 30))
                  add_byte(8'($urandom), $urandom_range(0, 7) == 0);
               counted += pending_bytes.size() - start;
            end
            1, 2: begin
               // broken off, possibly mid-value; the next one restarts
               add_trajectory($urandom_range(0, 3), drain);
               cut = $urandom_range(1, pending_bytes.size() - start - 1);
               while (pending_bytes.size() > start + cut) void'(pending_bytes.pop_back());
               counted += cut;
            end
            default: begin
               add_trajectory($urandom_range(0, 4), drain);
               counted += pending_bytes.size() - start;
               repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            end
         endcase
         round++;
      end

      // closing stretch without idling: long run of empty pieces of full duration
      calm_from = pending_bytes.size();
      add_byte(8'h00, 1'b1);
      add_byte(8'h00);
      repeat (3) add_word(16'h0000);
      repeat (ClosingPieces) begin
         add_byte(8'h00);
         add_word(16'hffff);
      end
      add_byte(8'h00);
      add_word(16'h0000);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d stream bytes parsed, %0d records checked, %0d trajectories ended",
               accepted_bytes, records_checked, ends_seen);
      $display("covered restarts mid-value, broken streams, long stalls and back-to-back bytes");
      if (mismatches == 0) begin
         $display("compressed_trajectory_parser_test OK");
      end else begin
         $display("compressed_trajectory_parser_test NOT OK");
      end
      $finish;
   end

endmodule
